// ===== src/i2cscrf_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cscrf_pkg: shared types and constants
// Operation codes, CRC constants and the request/response beats of the
// bit-serial CRC unit.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cscrf_pkg;

  localparam int REG_COUNT_DEF = 64;

  localparam logic [15:0] CRC_SEED  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h8408;
  localparam int          CRC_BITS  = 8;
  localparam logic [7:0]  BYTE_IDLE = 8'hFF;
  localparam logic [8:0]  TX_POS_MAX = 9'd511;

  typedef enum logic [3:0] {
    OP_WRITE_ADDR  = 4'd0,
    OP_RX_DATA     = 4'd1,
    OP_READ_ADDR   = 4'd2,
    OP_TX_ACK      = 4'd3,
    OP_STOP        = 4'd4,
    OP_NO_INFO     = 4'd5,
    OP_BUS_ERROR   = 4'd6,
    OP_LOCAL_WRITE = 4'd7,
    OP_LOCAL_READ  = 4'd8
  } op_t;

  typedef struct packed {
    logic        go;
    logic [15:0] seed;
    logic [7:0]  data;
  } crc_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] value;
  } crc_rsp_t;

endpackage

`default_nettype wire

// ===== src/i2c_slave_crc_register_file_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_slave_crc_register_file_unit: I2C slave register file with CRC framing
// Byte-level protocol engine driven by decoded bus events, with a
// CRC-16 checked write frame, a staging buffer and local register access.
// ----------------------------------------------------------------------------
// Each event is one beat on start/operation/rx_byte/local_index/local_value,
// taken when start is high and busy is low. Every event returns exactly one
// result beat: done is high for one cycle with tx_byte, tx_loaded,
// stop_request, frame_committed and local_data valid in that cycle; the
// receiver cannot stall, so sample them then. The CRC unit works one bit
// per cycle; write address bytes, received start, length and payload
// bytes, read address bytes and register bytes sent on a read are folded
// into the CRC and wait for it. A local read waits for the registered
// register file read. The final CRC byte of a good frame copies the
// staging buffer into the register file one byte per cycle. There is no
// clearing pass after reset: the register file reads zero until each
// entry is written.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_slave_crc_register_file_unit #(
  parameter  int REG_COUNT = i2cscrf_pkg::REG_COUNT_DEF,
  localparam int AW        = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [3:0] operation,
  input  logic [7:0] rx_byte,
  input  logic [5:0] local_index,
  input  logic [7:0] local_value,
  output logic       done,
  output logic [7:0] tx_byte,
  output logic       tx_loaded,
  output logic       stop_request,
  output logic       frame_committed,
  output logic [7:0] local_data
);

  localparam logic [8:0] RX_LIMIT   = 9'(REG_COUNT + 4);
  localparam logic [7:0] RX_ERR_POS = 8'(REG_COUNT + 3);
  localparam logic [8:0] TX_ERR_POS = 9'(REG_COUNT);
  localparam logic [9:0] REG_LIM10  = 10'(REG_COUNT);
  localparam logic [8:0] REG_LIM9   = 9'(REG_COUNT);

  // sequencer states
  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_CRC_PRE = 7'b0000010, // read address byte in the CRC, then first tx byte
    S_TXSEL   = 7'b0000100, // pick the next byte of a read
    S_RDREG   = 7'b0001000, // register byte back, fold it into the CRC
    S_CRC     = 7'b0010000, // wait for the CRC unit, then finish
    S_LREAD   = 7'b0100000, // local read data back
    S_COPY    = 7'b1000000  // commit staging buffer into the register file
  } state_t;

  state_t state, state_next;

  // protocol state
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] received_crc, received_crc_next;
  logic [7:0]  start_index, start_index_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [7:0]  rx_position, rx_position_next;
  logic [8:0]  tx_position, tx_position_next;

  // commit copy
  logic [7:0]    copy_idx, copy_idx_next;
  logic          cp_wvalid, cp_wvalid_next;
  logic [AW-1:0] cp_widx, cp_widx_next;

  // result beat
  logic       done_q, done_next;
  logic [7:0] res_tx, res_tx_next;
  logic       res_loaded, res_loaded_next;
  logic       res_stop, res_stop_next;
  logic       res_committed, res_committed_next;
  logic [7:0] res_local, res_local_next;

  // shared CRC unit
  i2cscrf_pkg::crc_req_t crc_req;
  i2cscrf_pkg::crc_rsp_t crc_rsp;

  // register file ports
  logic          rf_wr_en;
  logic [AW-1:0] rf_wr_addr;
  logic [7:0]    rf_wr_data;
  logic          rf_rd_en;
  logic [AW-1:0] rf_rd_addr;
  logic [7:0]    rf_rd_data;

  // staging buffer
  logic [7:0]    stage_mem [REG_COUNT];
  logic          stage_wen;
  logic [AW-1:0] stage_waddr;
  logic          stage_ren;
  logic [AW-1:0] stage_raddr;
  logic [7:0]    stage_rdata;

  // decode helpers
  logic [7:0] rx_start_new;
  logic       rx_adv;
  logic       frame_fits;
  logic [9:0] rx_pos10;
  logic [9:0] len_p2;
  logic [9:0] len_p3;
  logic [9:0] rx_stage_addr;
  logic       crc_match;
  logic [9:0] tx_idx;
  logic [9:0] tx_pos10;
  logic [9:0] tx_len10;
  logic [8:0] li9;
  logic       li_ok;
  logic [8:0] copy_addr;

  i2cscrf_crc u_crc (
    .clk (clk),
    .rst (rst),
    .req (crc_req),
    .rsp (crc_rsp)
  );

  i2cscrf_regfile #(
    .REG_COUNT (REG_COUNT)
  ) u_regfile (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rf_wr_en),
    .wr_addr (rf_wr_addr),
    .wr_data (rf_wr_data),
    .rd_en   (rf_rd_en),
    .rd_addr (rf_rd_addr),
    .rd_data (rf_rd_data)
  );

  always_ff @(posedge clk) begin
    if (stage_wen) begin
      stage_mem[stage_waddr] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ren) begin
      stage_rdata <= stage_mem[stage_raddr];
    end
  end

  // the start index written by this very byte counts for the advance check
  assign rx_start_new  = (rx_position == 8'd0) ? rx_byte : start_index;
  assign rx_adv        = ({1'b0, rx_start_new} + {1'b0, rx_position}) < RX_LIMIT;
  assign frame_fits    = ({2'b00, start_index} + {2'b00, frame_length}) <= REG_LIM10;
  assign rx_pos10      = {2'b00, rx_position};
  assign len_p2        = {2'b00, frame_length} + 10'd2;
  assign len_p3        = {2'b00, frame_length} + 10'd3;
  assign rx_stage_addr = rx_pos10 - 10'd2;
  assign crc_match     = (running_crc == {received_crc[15:8], rx_byte});
  assign tx_idx        = {2'b00, start_index} + {1'b0, tx_position};
  assign tx_pos10      = {1'b0, tx_position};
  assign tx_len10      = {2'b00, frame_length};
  assign li9           = {3'b000, local_index};
  assign li_ok         = li9 < REG_LIM9;
  assign copy_addr     = {1'b0, start_index} + 9'(cp_widx);

  always_comb begin
    state_next         = state;
    running_crc_next   = running_crc;
    received_crc_next  = received_crc;
    start_index_next   = start_index;
    frame_length_next  = frame_length;
    rx_position_next   = rx_position;
    tx_position_next   = tx_position;
    copy_idx_next      = copy_idx;
    cp_wvalid_next     = cp_wvalid;
    cp_widx_next       = cp_widx;
    done_next          = 1'b0;
    res_tx_next        = res_tx;
    res_loaded_next    = res_loaded;
    res_stop_next      = res_stop;
    res_committed_next = res_committed;
    res_local_next     = res_local;
    crc_req            = '0;
    rf_wr_en           = 1'b0;
    rf_wr_addr         = '0;
    rf_wr_data         = local_value;
    rf_rd_en           = 1'b0;
    rf_rd_addr         = '0;
    stage_wen          = 1'b0;
    stage_waddr        = rx_stage_addr[AW-1:0];
    stage_ren          = 1'b0;
    stage_raddr        = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          res_tx_next        = 8'h00;
          res_loaded_next    = 1'b0;
          res_stop_next      = 1'b0;
          res_committed_next = 1'b0;
          res_local_next     = 8'h00;
          unique case (i2cscrf_pkg::op_t'(operation))
            i2cscrf_pkg::OP_WRITE_ADDR: begin
              // reseed and fold in the slave address
              crc_req          = '{go: 1'b1, seed: i2cscrf_pkg::CRC_SEED, data: rx_byte};
              rx_position_next = 8'd0;
              state_next       = S_CRC;
            end
            i2cscrf_pkg::OP_RX_DATA: begin
              if (rx_adv) begin
                rx_position_next = rx_position + 8'd1;
              end
              if (rx_position == 8'd0) begin
                start_index_next = rx_byte;
                crc_req          = '{go: 1'b1, seed: running_crc, data: rx_byte};
                state_next       = S_CRC;
              end else if (rx_position == 8'd1) begin
                frame_length_next = rx_byte;
                crc_req           = '{go: 1'b1, seed: running_crc, data: rx_byte};
                state_next        = S_CRC;
              end else if (frame_fits) begin
                if (rx_pos10 < len_p2) begin
                  // payload byte: stage it and fold it in
                  stage_wen  = 1'b1;
                  crc_req    = '{go: 1'b1, seed: running_crc, data: rx_byte};
                  state_next = S_CRC;
                end else if (rx_pos10 == len_p2) begin
                  received_crc_next = {rx_byte, ~running_crc[7:0]};
                  done_next         = 1'b1;
                end else if (rx_pos10 == len_p3) begin
                  received_crc_next = {received_crc[15:8], rx_byte};
                  if (crc_match) begin
                    res_committed_next = 1'b1;
                    copy_idx_next      = 8'd0;
                    cp_wvalid_next     = 1'b0;
                    state_next         = S_COPY;
                  end else begin
                    done_next = 1'b1;
                  end
                end else begin
                  received_crc_next = {8'h00, rx_byte};
                  done_next         = 1'b1;
                end
              end else begin
                // frame out of range: drop the byte into received_crc only
                received_crc_next = {8'h00, rx_byte};
                done_next         = 1'b1;
              end
            end
            i2cscrf_pkg::OP_READ_ADDR: begin
              crc_req         = '{go: 1'b1, seed: running_crc, data: rx_byte};
              res_loaded_next = 1'b1;
              state_next      = S_CRC_PRE;
            end
            i2cscrf_pkg::OP_TX_ACK: begin
              res_loaded_next = 1'b1;
              state_next      = S_TXSEL;
            end
            i2cscrf_pkg::OP_STOP: begin
              res_tx_next     = i2cscrf_pkg::BYTE_IDLE;
              res_loaded_next = 1'b1;
              done_next       = 1'b1;
            end
            i2cscrf_pkg::OP_NO_INFO: begin
              done_next = 1'b1;
            end
            i2cscrf_pkg::OP_LOCAL_WRITE: begin
              rf_wr_en   = li_ok;
              rf_wr_addr = li9[AW-1:0];
              rf_wr_data = local_value;
              done_next  = 1'b1;
            end
            i2cscrf_pkg::OP_LOCAL_READ: begin
              if (li_ok) begin
                rf_rd_en   = 1'b1;
                rf_rd_addr = li9[AW-1:0];
                state_next = S_LREAD;
              end else begin
                done_next = 1'b1;
              end
            end
            default: begin
              // bus error and unused codes: park both positions, ask for stop
              rx_position_next = RX_ERR_POS;
              tx_position_next = TX_ERR_POS;
              res_tx_next      = i2cscrf_pkg::BYTE_IDLE;
              res_loaded_next  = 1'b1;
              res_stop_next    = 1'b1;
              done_next        = 1'b1;
            end
          endcase
        end
      end

      S_CRC_PRE: begin
        if (crc_rsp.done) begin
          running_crc_next = crc_rsp.value;
          tx_position_next = 9'd0;
          state_next       = S_TXSEL;
        end
      end

      S_TXSEL: begin
        if (tx_position != i2cscrf_pkg::TX_POS_MAX) begin
          tx_position_next = tx_position + 9'd1;
        end
        if (tx_pos10 < tx_len10) begin
          if (tx_idx < REG_LIM10) begin
            rf_rd_en   = 1'b1;
            rf_rd_addr = tx_idx[AW-1:0];
            state_next = S_RDREG;
          end else begin
            res_tx_next = i2cscrf_pkg::BYTE_IDLE;
            done_next   = 1'b1;
            state_next  = S_IDLE;
          end
        end else begin
          if (tx_pos10 == tx_len10) begin
            res_tx_next = running_crc[15:8];
          end else if (tx_pos10 == tx_len10 + 10'd1) begin
            res_tx_next = running_crc[7:0];
          end else begin
            res_tx_next = i2cscrf_pkg::BYTE_IDLE;
          end
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_RDREG: begin
        res_tx_next = rf_rd_data;
        crc_req     = '{go: 1'b1, seed: running_crc, data: rf_rd_data};
        state_next  = S_CRC;
      end

      S_CRC: begin
        if (crc_rsp.done) begin
          running_crc_next = crc_rsp.value;
          done_next        = 1'b1;
          state_next       = S_IDLE;
        end
      end

      S_LREAD: begin
        res_local_next = rf_rd_data;
        done_next      = 1'b1;
        state_next     = S_IDLE;
      end

      S_COPY: begin
        // read side: one staging entry a cycle
        if (copy_idx < frame_length) begin
          stage_ren      = 1'b1;
          stage_raddr    = copy_idx[AW-1:0];
          copy_idx_next  = copy_idx + 8'd1;
          cp_wvalid_next = 1'b1;
          cp_widx_next   = copy_idx[AW-1:0];
        end else begin
          cp_wvalid_next = 1'b0;
        end
        // write side: in the cycle after the read
        if (cp_wvalid) begin
          rf_wr_en   = 1'b1;
          rf_wr_addr = copy_addr[AW-1:0];
          rf_wr_data = stage_rdata;
        end
        if ((copy_idx >= frame_length) && !cp_wvalid) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running_crc   <= 16'h0000;
      received_crc  <= 16'h0000;
      start_index   <= 8'd0;
      frame_length  <= 8'd0;
      rx_position   <= 8'd0;
      tx_position   <= 9'd0;
      copy_idx      <= 8'd0;
      cp_wvalid     <= 1'b0;
      done_q        <= 1'b0;
      res_tx        <= 8'h00;
      res_loaded    <= 1'b0;
      res_stop      <= 1'b0;
      res_committed <= 1'b0;
      res_local     <= 8'h00;
    end else begin
      state         <= state_next;
      running_crc   <= running_crc_next;
      received_crc  <= received_crc_next;
      start_index   <= start_index_next;
      frame_length  <= frame_length_next;
      rx_position   <= rx_position_next;
      tx_position   <= tx_position_next;
      copy_idx      <= copy_idx_next;
      cp_wvalid     <= cp_wvalid_next;
      done_q        <= done_next;
      res_tx        <= res_tx_next;
      res_loaded    <= res_loaded_next;
      res_stop      <= res_stop_next;
      res_committed <= res_committed_next;
      res_local     <= res_local_next;
    end
  end

  always_ff @(posedge clk) begin
    cp_widx <= cp_widx_next;
  end

  assign busy            = (state != S_IDLE);
  assign done            = done_q;
  assign tx_byte         = res_tx;
  assign tx_loaded       = res_loaded;
  assign stop_request    = res_stop;
  assign frame_committed = res_committed;
  assign local_data      = res_local;

`ifndef ASSERT_OFF
  // commit writes never leave the register file
  a_copy_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY && cp_wvalid) |-> (copy_addr < REG_LIM9))
    else $error("commit copy address beyond the register file");

  // every CRC launch is followed by a wait on the CRC unit
  a_crc_wait: assert property (@(posedge clk) disable iff (rst)
    crc_req.go |=> (state == S_CRC || state == S_CRC_PRE))
    else $error("CRC launched without waiting for it");

  // a copy runs only for a frame that passed its check
  a_copy_committed: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY) |-> frame_committed)
    else $error("copy running without a committed frame");

  // a stop request always carries an idle byte
  a_stop_byte: assert property (@(posedge clk) disable iff (rst)
    (done && stop_request) |-> (tx_loaded && tx_byte == i2cscrf_pkg::BYTE_IDLE))
    else $error("stop request without idle byte loaded");
`endif

endmodule

`default_nettype wire

// ===== src/i2cscrf_crc.sv =====
// ----------------------------------------------------------------------------
// i2cscrf_crc: bit-serial reflected CCITT CRC unit
// Folds one byte into a 16-bit CRC, one bit per cycle, LSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cscrf_crc (
  input  logic                  clk,
  input  logic                  rst,
  input  i2cscrf_pkg::crc_req_t req,
  output i2cscrf_pkg::crc_rsp_t rsp
);

  logic [15:0] crc;
  logic [2:0]  bit_cnt;
  logic        active;
  logic        done;

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      done    <= 1'b0;
      bit_cnt <= 3'd0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        active  <= 1'b1;
        bit_cnt <= 3'd0;
      end else if (active) begin
        bit_cnt <= bit_cnt + 3'd1;
        if (bit_cnt == 3'(i2cscrf_pkg::CRC_BITS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // shift one bit per cycle; xor in the reflected polynomial on a set LSB
  always_ff @(posedge clk) begin
    if (req.go) begin
      crc <= req.seed ^ {8'h00, req.data};
    end else if (active) begin
      crc <= crc[0] ? ((crc >> 1) ^ i2cscrf_pkg::CRC_POLY) : (crc >> 1);
    end
  end

  assign rsp.done  = done;
  assign rsp.value = crc;

endmodule

`default_nettype wire

// ===== src/i2cscrf_regfile.sv =====
// ----------------------------------------------------------------------------
// i2cscrf_regfile: application register file
// One write port, one registered read port; per-entry valid bits make
// never-written entries read as zero straight out of reset.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cscrf_regfile #(
  parameter  int REG_COUNT = i2cscrf_pkg::REG_COUNT_DEF,
  localparam int AW        = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0]           mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : 8'h00;
    end
  end

endmodule

`default_nettype wire

// ===== test/i2c_slave_crc_register_file_unit_tb.sv =====
// ----------------------------------------------------------------------------
// i2c_slave_crc_register_file_unit_tb: self-checking bench for the I2C slave
// Drives decoded bus events (write frames with CRC-16, reads, local access,
// bus errors and junk codes) in random bursts and checks every result beat
// against a cycle-free model of the register file, staging buffer and CRC.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_slave_crc_register_file_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REG_COUNT   = i2cscrf_pkg::REG_COUNT_DEF;
  localparam int ITEM_TARGET = 600;
  localparam int SATURATE_ACKS = 460;  // acks after a bus error to pin the tx position at 511
  localparam int STALL_LIMIT = 500;    // cycles with no beat in or out before giving up
  localparam int TAIL_CYCLES = 70;     // longest event: a full 64-byte commit plus margin

  // One bus event as the driver presents it.
  typedef struct packed {
    logic [3:0] operation;
    logic [7:0] rx_byte;
    logic [5:0] local_index;
    logic [7:0] local_value;
  } bus_event_t;

  // One result beat as the block reports it.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_loaded;
    logic       stop_request;
    logic       frame_committed;
    logic [7:0] local_data;
  } slave_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [3:0] operation = i2cscrf_pkg::OP_NO_INFO;
  logic [7:0] rx_byte = 8'h00;
  logic [5:0] local_index = 6'd0;
  logic [7:0] local_value = 8'h00;
  logic       done;
  logic [7:0] tx_byte;
  logic       tx_loaded;
  logic       stop_request;
  logic       frame_committed;
  logic [7:0] local_data;

  i2c_slave_crc_register_file_unit #(
    .REG_COUNT(REG_COUNT)
  ) i_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .operation       (operation),
    .rx_byte         (rx_byte),
    .local_index     (local_index),
    .local_value     (local_value),
    .done            (done),
    .tx_byte         (tx_byte),
    .tx_loaded       (tx_loaded),
    .stop_request    (stop_request),
    .frame_committed (frame_committed),
    .local_data      (local_data)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Slave model: register file, staging buffer, CRC and frame positions.
  // Advanced once per accepted event, in acceptance order.
  // --------------------------------------------------------------------------
  logic [7:0]           reg_file [REG_COUNT];
  logic [7:0]           staging  [REG_COUNT];
  bit   [REG_COUNT-1:0] staged;     // staging entries written at least once since reset
  logic [15:0]          crc_run;
  logic [15:0]          crc_rcvd;
  logic [7:0]           frame_start;
  logic [7:0]           frame_len;
  logic [7:0]           rx_pos;
  logic [8:0]           tx_pos;

  initial begin
    foreach (reg_file[i]) reg_file[i] = 8'h00;
    foreach (staging[i]) staging[i] = 8'h00;
    staged      = '0;
    crc_run     = 16'h0000;
    crc_rcvd    = 16'h0000;
    frame_start = 8'h00;
    frame_len   = 8'h00;
    rx_pos      = 8'h00;
    tx_pos      = 9'd0;
  end

  // Reflected CCITT update, LSB first.
  function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ i2cscrf_pkg::CRC_POLY) : (c >> 1);
    return c;
  endfunction

  // Next byte of a read: register bytes (folded into the CRC), 0xFF past the
  // file, then CRC high, CRC low, then 0xFF. The position sticks at its top.
  function automatic logic [7:0] load_tx_byte();
    logic [7:0] v;
    int pos;
    int len;
    int idx;
    pos = int'(tx_pos);
    len = int'(frame_len);
    idx = int'(frame_start) + pos;
    if (pos < len) begin
      if (idx < REG_COUNT) begin
        v = reg_file[idx];
        crc_run = crc_fold(crc_run, v);
      end else begin
        v = i2cscrf_pkg::BYTE_IDLE;
      end
    end else if (pos == len) begin
      v = crc_run[15:8];
    end else if (pos == len + 1) begin
      v = crc_run[7:0];
    end else begin
      v = i2cscrf_pkg::BYTE_IDLE;
    end
    if (tx_pos != i2cscrf_pkg::TX_POS_MAX) tx_pos = tx_pos + 9'd1;
    return v;
  endfunction

  function automatic slave_result_t apply_event(bus_event_t ev);
    slave_result_t r;
    int pos;
    int len;
    int first;
    r = '0;
    pos = int'(rx_pos);
    len = int'(frame_len);
    first = int'(frame_start);
    case (ev.operation)
      i2cscrf_pkg::OP_WRITE_ADDR: begin
        crc_run = crc_fold(i2cscrf_pkg::CRC_SEED, ev.rx_byte);
        rx_pos = 8'h00;
      end
      i2cscrf_pkg::OP_RX_DATA: begin
        if (pos == 0) begin
          frame_start = ev.rx_byte;
          crc_run = crc_fold(crc_run, ev.rx_byte);
        end else if (pos == 1) begin
          frame_len = ev.rx_byte;
          crc_run = crc_fold(crc_run, ev.rx_byte);
        end else if (first + len <= REG_COUNT) begin
          if (pos < len + 2) begin
            staging[pos - 2] = ev.rx_byte;
            staged[pos - 2] = 1'b1;
            crc_run = crc_fold(crc_run, ev.rx_byte);
          end else if (pos == len + 2) begin
            // high byte lands; low half holds the complement until the next byte
            crc_rcvd = {ev.rx_byte, ~crc_run[7:0]};
          end else if (pos == len + 3) begin
            crc_rcvd[7:0] = ev.rx_byte;
            if (crc_run == crc_rcvd) begin
              for (int i = 0; i < len; i++) reg_file[first + i] = staging[i];
              r.frame_committed = 1'b1;
            end
          end else begin
            crc_rcvd = {8'h00, ev.rx_byte};
          end
        end else begin
          // frame does not fit: every byte after the length just lands here
          crc_rcvd = {8'h00, ev.rx_byte};
        end
        if (int'(frame_start) + int'(rx_pos) < REG_COUNT + 4) rx_pos = rx_pos + 8'd1;
      end
      i2cscrf_pkg::OP_READ_ADDR: begin
        crc_run = crc_fold(crc_run, ev.rx_byte);
        tx_pos = 9'd0;
        r.tx_byte = load_tx_byte();
        r.tx_loaded = 1'b1;
      end
      i2cscrf_pkg::OP_TX_ACK: begin
        r.tx_byte = load_tx_byte();
        r.tx_loaded = 1'b1;
      end
      i2cscrf_pkg::OP_STOP: begin
        r.tx_byte = i2cscrf_pkg::BYTE_IDLE;
        r.tx_loaded = 1'b1;
      end
      i2cscrf_pkg::OP_NO_INFO: begin
      end
      i2cscrf_pkg::OP_LOCAL_WRITE: begin
        if (int'(ev.local_index) < REG_COUNT) reg_file[ev.local_index] = ev.local_value;
      end
      i2cscrf_pkg::OP_LOCAL_READ: begin
        if (int'(ev.local_index) < REG_COUNT) r.local_data = reg_file[ev.local_index];
      end
      default: begin
        // bus error and every unused code: park both positions, release the bus
        rx_pos = 8'(REG_COUNT + 3);
        tx_pos = 9'(REG_COUNT);
        r.tx_byte = i2cscrf_pkg::BYTE_IDLE;
        r.tx_loaded = 1'b1;
        r.stop_request = 1'b1;
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus building: events go into a queue that the driver drains.
  // --------------------------------------------------------------------------
  bus_event_t    pending_events [$];
  slave_result_t expected_results [$];

  task automatic queue_event(logic [3:0] op, logic [7:0] rx, logic [5:0] idx, logic [7:0] val);
    pending_events.push_back({op, rx, idx, val});
  endtask

  // Bus events leave the local fields as random junk.
  task automatic queue_bus(logic [3:0] op, logic [7:0] rx);
    queue_event(op, rx, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
  endtask

  // Address, start, length, data, CRC high, CRC low. A corrupt frame flips one
  // CRC bit; keep >= 0 cuts the frame after that many bytes past the address.
  task automatic queue_write_frame(logic [7:0] first, logic [7:0] len, bit corrupt, int keep);
    logic [7:0]  body [$];
    logic [15:0] crc;
    logic [7:0]  addr;
    addr = 8'($urandom_range(0, 255));
    crc = crc_fold(i2cscrf_pkg::CRC_SEED, addr);
    body.push_back(first);
    body.push_back(len);
    for (int i = 0; i < int'(len); i++) body.push_back(8'($urandom_range(0, 255)));
    foreach (body[i]) crc = crc_fold(crc, body[i]);
    if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    body.push_back(crc[15:8]);
    body.push_back(crc[7:0]);
    queue_bus(i2cscrf_pkg::OP_WRITE_ADDR, addr);
    foreach (body[i]) if (keep < 0 || i < keep) queue_bus(i2cscrf_pkg::OP_RX_DATA, body[i]);
  endtask

  task automatic queue_read(int acks);
    queue_bus(i2cscrf_pkg::OP_READ_ADDR, 8'($urandom_range(0, 255)));
    repeat (acks) queue_bus(i2cscrf_pkg::OP_TX_ACK, 8'($urandom_range(0, 255)));
    queue_bus(i2cscrf_pkg::OP_STOP, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int         pick;
    int         len;
    int         lo;
    logic [5:0] idx;

    // Directed opening: field extremes, zero-length read, zero-length frame,
    // extra bytes, an out-of-range frame that runs into the position limit,
    // bus error and unused codes.
    queue_event(i2cscrf_pkg::OP_LOCAL_READ, 8'h00, 6'd0, 8'h00);
    queue_event(i2cscrf_pkg::OP_LOCAL_WRITE, 8'hFF, 6'd63, 8'hFF);
    queue_event(i2cscrf_pkg::OP_LOCAL_READ, 8'hFF, 6'd63, 8'h00);
    queue_event(i2cscrf_pkg::OP_LOCAL_WRITE, 8'h00, 6'd0, 8'h00);
    queue_bus(i2cscrf_pkg::OP_READ_ADDR, 8'h00);
    repeat (3) queue_bus(i2cscrf_pkg::OP_TX_ACK, 8'hFF);
    queue_bus(i2cscrf_pkg::OP_STOP, 8'h00);
    queue_write_frame(8'd0, 8'd0, 1'b0, -1);
    queue_bus(i2cscrf_pkg::OP_RX_DATA, 8'hFF);
    queue_write_frame(8'd63, 8'd2, 1'b0, -1);
    queue_bus(i2cscrf_pkg::OP_RX_DATA, 8'h00);
    queue_bus(i2cscrf_pkg::OP_RX_DATA, 8'hFF);
    queue_bus(i2cscrf_pkg::OP_BUS_ERROR, 8'h00);
    queue_bus(4'hF, 8'hFF);
    queue_bus(4'h9, 8'h00);

    // Random episodes, mostly well-formed frames and reads.
    while (pending_events.size() < ITEM_TARGET - SATURATE_ACKS - 2) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, REG_COUNT) : $urandom_range(0, 8);
        queue_write_frame(8'($urandom_range(0, REG_COUNT - len)), 8'(len),
                          $urandom_range(0, 4) == 0, -1);
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3))
            queue_bus(i2cscrf_pkg::OP_RX_DATA, 8'($urandom_range(0, 255)));
      end else if (pick < 45) begin
        len = $urandom_range(1, 16);
        if ($urandom_range(0, 1) == 0) begin
          // does not fit: start pushed so the frame runs past the end of the file
          lo = REG_COUNT + 1 - len;
          queue_write_frame(8'($urandom_range(lo, 255)), 8'(len), 1'b0, -1);
        end else begin
          queue_write_frame(8'($urandom_range(0, REG_COUNT - len)), 8'(len), 1'b0,
                            $urandom_range(0, len + 3));
        end
        case ($urandom_range(0, 3))
          0: queue_bus(i2cscrf_pkg::OP_BUS_ERROR, 8'($urandom_range(0, 255)));
          1: queue_bus(4'($urandom_range(9, 15)), 8'($urandom_range(0, 255)));
          2: queue_bus(i2cscrf_pkg::OP_STOP, 8'($urandom_range(0, 255)));
          default: ;
        endcase
        if ($urandom_range(0, 1) == 0)
          repeat ($urandom_range(1, 3))
            queue_bus(i2cscrf_pkg::OP_RX_DATA, 8'($urandom_range(0, 255)));
      end else if (pick < 70) begin
        queue_read(($urandom_range(0, 7) == 0) ? $urandom_range(13, 70) : $urandom_range(0, 12));
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) begin
          idx = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 6'd63 : 6'd0)
                                            : 6'($urandom_range(0, 63));
          if ($urandom_range(0, 1) == 0)
            queue_event(i2cscrf_pkg::OP_LOCAL_WRITE, 8'($urandom_range(0, 255)), idx,
                        8'($urandom_range(0, 255)));
          else
            queue_event(i2cscrf_pkg::OP_LOCAL_READ, 8'($urandom_range(0, 255)), idx,
                        8'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 4))
          queue_event(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                      6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
      end
    end

    // Park the transmit position with a bus error, then ack until it saturates.
    queue_bus(i2cscrf_pkg::OP_BUS_ERROR, 8'($urandom_range(0, 255)));
    repeat (SATURATE_ACKS) queue_bus(i2cscrf_pkg::OP_TX_ACK, 8'($urandom_range(0, 255)));
    queue_bus(i2cscrf_pkg::OP_STOP, 8'($urandom_range(0, 255)));
  end

  // --------------------------------------------------------------------------
  // Reset: held from time zero, then released for good.
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Driver: present one event beat at a time in bursts with random gaps.
  // A beat is taken at an edge with start high and busy low; its expected
  // result is worked out right there, so the model always sees the events in
  // the order the block took them.
  // --------------------------------------------------------------------------
  bus_event_t current_ev;
  bus_event_t next_ev;
  int         burst_left = 1;
  int         gap_left = 0;
  int         beats_driven = 0;
  int         beats_dropped = 0;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(apply_event(current_ev));
        beats_driven++;
      end
      // hold the current beat while the block is busy; otherwise move on
      if (!start || !busy) begin
        if (gap_left != 0 || pending_events.size() == 0) begin
          if (gap_left != 0) gap_left--;
          start <= 1'b0;
        end else begin
          next_ev = pending_events.pop_front();
          // Drop a data byte that would commit staging entries never written
          // since reset (only reachable by parking rx_pos with a bus error on
          // a frame that spans the whole file).
          if (next_ev.operation == i2cscrf_pkg::OP_RX_DATA &&
              int'(rx_pos) == int'(frame_len) + 3 &&
              int'(frame_start) + int'(frame_len) <= REG_COUNT) begin
            for (int i = 0; i < int'(frame_len); i++)
              if (!staged[i]) next_ev.operation = i2cscrf_pkg::OP_NO_INFO;
            if (next_ev.operation == i2cscrf_pkg::OP_NO_INFO) beats_dropped++;
          end
          current_ev  = next_ev;
          operation   <= next_ev.operation;
          rx_byte     <= next_ev.rx_byte;
          local_index <= next_ev.local_index;
          local_value <= next_ev.local_value;
          start       <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every done beat is compared with the oldest expectation.
  // The block cannot be held off, so it is sampled on each done edge.
  // --------------------------------------------------------------------------
  slave_result_t want;
  int            mismatch_count = 0;
  int            results_checked = 0;
  int            commits_seen = 0;
  int            stops_seen = 0;
  int            loads_seen = 0;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no event outstanding");
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (tx_byte !== want.tx_byte) begin
          $error("tx_byte: expected %02h, got %02h", want.tx_byte, tx_byte);
          mismatch_count++;
        end
        if (tx_loaded !== want.tx_loaded) begin
          $error("tx_loaded: expected %0b, got %0b", want.tx_loaded, tx_loaded);
          mismatch_count++;
        end
        if (stop_request !== want.stop_request) begin
          $error("stop_request: expected %0b, got %0b", want.stop_request, stop_request);
          mismatch_count++;
        end
        if (frame_committed !== want.frame_committed) begin
          $error("frame_committed: expected %0b, got %0b", want.frame_committed,
                 frame_committed);
          mismatch_count++;
        end
        if (local_data !== want.local_data) begin
          $error("local_data: expected %02h, got %02h", want.local_data, local_data);
          mismatch_count++;
        end
        results_checked++;
        if (want.frame_committed) commits_seen++;
        if (want.stop_request) stops_seen++;
        if (want.tx_loaded) loads_seen++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if nothing moves in or out for too long.
  // --------------------------------------------------------------------------
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results outstanding",
               STALL_LIMIT, expected_results.size());
      $display("i2c_slave_crc_register_file_unit_tb: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // End of run: drain, let the block settle, report.
  // --------------------------------------------------------------------------
  initial begin
    @(negedge rst);
    @(posedge clk);
    while (pending_events.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d events (%0d parked bytes dropped), %0d results checked",
             beats_driven, beats_dropped, results_checked);
    $display("  %0d frames committed, %0d stop requests, %0d tx bytes loaded",
             commits_seen, stops_seen, loads_seen);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("i2c_slave_crc_register_file_unit_tb: PASS");
    end else begin
      $display("i2c_slave_crc_register_file_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
src/i2cscrf_pkg.sv
src/i2cscrf_crc.sv
src/i2cscrf_regfile.sv
src/i2c_slave_crc_register_file_unit.sv
test/i2c_slave_crc_register_file_unit_tb.sv
